>>> rtl/cha_pkg.sv
// Shared constants, codes and types of the cache hit analyzer.
`default_nettype none
package cha_pkg;

   localparam int ADDR_PORT_W    = 32;
   localparam int CNT_W          = 32;
   localparam int OFF_MIN        = 4;
   localparam int OFF_MAX        = 8;
   localparam int TAG_W          = ADDR_PORT_W - OFF_MIN;
   localparam int ENTRY_W        = TAG_W + 1;
   localparam int LANE_W         = 3;
   localparam int LANES          = 1 << LANE_W;
   localparam int WORD_W         = LANES * ENTRY_W;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 4;
   localparam int DEF_MAX_BLOCKS = 512;
   localparam int DEF_ADDR_WIDTH = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LOG2  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] OFFSET_RESET = 4'd6;
   localparam logic [CSR_DATA_W-1:0] LOG2_RESET   = 4'd5;

   localparam logic MODE_DIRECT = 1'b0;
   localparam logic MODE_ASSOC  = 1'b1;
   localparam logic KIND_INSTR  = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   typedef struct packed {
      logic valid;
      logic hit;
      logic kind;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/cha_tag_ram.sv
// Tag and valid memory, one write port and one registered read port.
`default_nettype none
module cha_tag_ram #(
   parameter int WORDS = 64,
   parameter int AW    = 6,
   parameter int DW    = 232
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem_ff [WORDS];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/cha_lookup.sv
// Lookup sequencer: clearing pass, tag scan, hit decision and refill.
`default_nettype none
module cha_lookup #(
   parameter int ADDR_WIDTH = cha_pkg::DEF_ADDR_WIDTH,
   parameter int WORDS      = 64,
   parameter int WORD_AW    = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cha_pkg::ADDR_PORT_W-1:0]     req_address,
   input  wire logic                                req_kind,
   input  wire logic                                cfg_mode,
   input  wire logic [cha_pkg::CSR_DATA_W-1:0]      cfg_offset,
   input  wire logic [cha_pkg::CSR_DATA_W-1:0]      cfg_log2,
   output logic                                     rd_en,
   output logic      [WORD_AW-1:0]                  rd_addr,
   input  wire logic [cha_pkg::WORD_W-1:0]          rd_data,
   output logic                                     wr_en,
   output logic      [WORD_AW-1:0]                  wr_addr,
   output logic      [cha_pkg::WORD_W-1:0]          wr_data,
   output cha_pkg::result_type                      res
);

   localparam int ENT_W = WORD_AW + cha_pkg::LANE_W;
   localparam logic [cha_pkg::ADDR_PORT_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= cha_pkg::ADDR_PORT_W) ? {cha_pkg::ADDR_PORT_W{1'b1}} :
      ((cha_pkg::ADDR_PORT_W'(1) << ADDR_WIDTH) - cha_pkg::ADDR_PORT_W'(1));

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [WORD_AW-1:0]                word_ff, word_in;
   logic [WORD_AW-1:0]                end_word_ff, end_word_in;
   logic [cha_pkg::TAG_W-1:0]         line_ff, line_in;
   logic                              kind_ff, kind_in;
   logic                              mode_ff, mode_in;
   logic [cha_pkg::CSR_DATA_W-1:0]    log2_ff, log2_in;
   logic [ENT_W:0]                    blocks_ff, blocks_in;
   logic [cha_pkg::TAG_W-1:0]         cmp_tag_ff, cmp_tag_in;
   logic [ENT_W-1:0]                  target_ff, target_in;
   logic [ENT_W-1:0]                  ptr_ff, ptr_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [WORD_AW-1:0]                rd_word_ff, rd_word_in;
   logic                              hit_acc_ff, hit_acc_in;
   logic [cha_pkg::WORD_W-1:0]        cap_ff, cap_in;

   logic [cha_pkg::ADDR_PORT_W-1:0]   line_full;
   logic [ENT_W:0]                    blocks_m1;
   logic [ENT_W-1:0]                  dm_index;
   logic [ENT_W-1:0]                  ptr_eff;
   logic [ENT_W:0]                    ptr_inc;
   logic [WORD_AW-1:0]                tgt_word;
   logic [cha_pkg::LANE_W-1:0]        tgt_lane;
   logic                              word_hit;
   logic [cha_pkg::WORD_W-1:0]        merged;
   logic                              accept;

   assign accept    = (state_ff == ST_IDLE) && start;
   assign line_full = (req_address & ADDR_MASK) >> cfg_offset;
   assign blocks_m1 = blocks_ff - (ENT_W + 1)'(1);
   assign dm_index  = ENT_W'(line_ff) & blocks_m1[ENT_W-1:0];
   assign ptr_eff   = ({1'b0, ptr_ff} >= blocks_ff) ? '0 : ptr_ff;
   assign ptr_inc   = {1'b0, target_ff} + (ENT_W + 1)'(1);
   assign tgt_word  = target_ff[ENT_W-1:cha_pkg::LANE_W];
   assign tgt_lane  = target_ff[cha_pkg::LANE_W-1:0];

   always_comb begin
      logic [ENT_W-1:0] entry;
      logic             lane_en;
      word_hit = 1'b0;
      for (int l = 0; l < cha_pkg::LANES; l++) begin
         entry = {rd_word_ff, cha_pkg::LANE_W'(l)};
         if (mode_ff == cha_pkg::MODE_ASSOC) begin
            lane_en = ({1'b0, entry} < blocks_ff);
         end else begin
            lane_en = (entry == target_ff);
         end
         if (lane_en && rd_data[l * cha_pkg::ENTRY_W + cha_pkg::TAG_W]
             && (rd_data[l * cha_pkg::ENTRY_W +: cha_pkg::TAG_W] == cmp_tag_ff)) begin
            word_hit = 1'b1;
         end
      end
   end

   always_comb begin
      merged = cap_ff;
      for (int l = 0; l < cha_pkg::LANES; l++) begin
         if (tgt_lane == cha_pkg::LANE_W'(l)) begin
            merged[l * cha_pkg::ENTRY_W +: cha_pkg::ENTRY_W] = {1'b1, cmp_tag_ff};
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      word_in     = word_ff;
      end_word_in = end_word_ff;
      line_in     = line_ff;
      kind_in     = kind_ff;
      mode_in     = mode_ff;
      log2_in     = log2_ff;
      blocks_in   = blocks_ff;
      cmp_tag_in  = cmp_tag_ff;
      target_in   = target_ff;
      ptr_in      = ptr_ff;
      rd_valid_in = (state_ff == ST_SCAN);
      rd_word_in  = word_ff;
      hit_acc_in  = hit_acc_ff | (rd_valid_ff & word_hit);
      cap_in      = (rd_valid_ff && (rd_word_ff == tgt_word)) ? rd_data : cap_ff;
      case (state_ff)
         ST_CLEAR: begin
            word_in = word_ff + WORD_AW'(1);
            if (word_ff == WORD_AW'(WORDS - 1)) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               line_in   = line_full[cha_pkg::TAG_W-1:0];
               kind_in   = req_kind;
               mode_in   = cfg_mode;
               log2_in   = cfg_log2;
               blocks_in = (ENT_W + 1)'(1) << cfg_log2;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            hit_acc_in = 1'b0;
            if (mode_ff == cha_pkg::MODE_ASSOC) begin
               cmp_tag_in  = line_ff;
               target_in   = ptr_eff;
               word_in     = '0;
               end_word_in = blocks_m1[ENT_W-1:cha_pkg::LANE_W];
            end else begin
               cmp_tag_in  = line_ff >> log2_ff;
               target_in   = dm_index;
               word_in     = dm_index[ENT_W-1:cha_pkg::LANE_W];
               end_word_in = dm_index[ENT_W-1:cha_pkg::LANE_W];
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            word_in = word_ff + WORD_AW'(1);
            if (word_ff == end_word_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!hit_acc_ff && (mode_ff == cha_pkg::MODE_ASSOC)) begin
               ptr_in = (ptr_inc >= blocks_ff) ? '0 : ptr_inc[ENT_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         word_ff     <= '0;
         ptr_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         word_ff     <= word_in;
         ptr_ff      <= ptr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_word_ff <= end_word_in;
      line_ff     <= line_in;
      kind_ff     <= kind_in;
      mode_ff     <= mode_in;
      log2_ff     <= log2_in;
      blocks_ff   <= blocks_in;
      cmp_tag_ff  <= cmp_tag_in;
      target_ff   <= target_in;
      rd_word_ff  <= rd_word_in;
      hit_acc_ff  <= hit_acc_in;
      cap_ff      <= cap_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = word_ff;
   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_DONE) && !hit_acc_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? word_ff : tgt_word;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : merged;

   assign res.valid = (state_ff == ST_DONE);
   assign res.hit   = hit_acc_ff;
   assign res.kind  = kind_ff;

endmodule
`default_nettype wire

>>> rtl/cha_counters.sv
// Saturating access and hit counters and the result registers.
`default_nettype none
module cha_counters (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cha_pkg::result_type                res,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [cha_pkg::CNT_W-1:0]          rsp_instr_accesses,
   output logic [cha_pkg::CNT_W-1:0]          rsp_instr_hits,
   output logic [cha_pkg::CNT_W-1:0]          rsp_data_access_count,
   output logic [cha_pkg::CNT_W-1:0]          rsp_data_hit_count
);

   logic                        valid_ff;
   logic                        hit_ff;
   logic [cha_pkg::CNT_W-1:0]   ia_ff, ia_in;
   logic [cha_pkg::CNT_W-1:0]   ih_ff, ih_in;
   logic [cha_pkg::CNT_W-1:0]   da_ff, da_in;
   logic [cha_pkg::CNT_W-1:0]   dh_ff, dh_in;

   function automatic logic [cha_pkg::CNT_W-1:0] sat_inc(
      input logic [cha_pkg::CNT_W-1:0] v
   );
      return (v == '1) ? v : v + cha_pkg::CNT_W'(1);
   endfunction

   always_comb begin
      ia_in = ia_ff;
      ih_in = ih_ff;
      da_in = da_ff;
      dh_in = dh_ff;
      if (res.valid) begin
         if (res.kind == cha_pkg::KIND_DATA) begin
            da_in = sat_inc(da_ff);
            if (res.hit) begin
               dh_in = sat_inc(dh_ff);
            end
         end else begin
            ia_in = sat_inc(ia_ff);
            if (res.hit) begin
               ih_in = sat_inc(ih_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ia_ff    <= '0;
         ih_ff    <= '0;
         da_ff    <= '0;
         dh_ff    <= '0;
      end else begin
         valid_ff <= res.valid;
         ia_ff    <= ia_in;
         ih_ff    <= ih_in;
         da_ff    <= da_in;
         dh_ff    <= dh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         hit_ff <= res.hit;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_hit               = hit_ff;
   assign rsp_instr_accesses    = ia_ff;
   assign rsp_instr_hits        = ih_ff;
   assign rsp_data_access_count = da_ff;
   assign rsp_data_hit_count    = dh_ff;

endmodule
`default_nettype wire

>>> rtl/cache_hit_analyzer.sv
// Top level of the cache hit analyzer: configuration registers and block wiring.
//
// After reset the block clears its tag memory, one word of eight entries per
// cycle, and holds busy high until the last word is cleared. An access is
// transferred when start is high and busy is low. It then holds busy high, and
// takes no new access, through the prepare, scan, finish and done states; the
// scan reads one tag memory word in direct-mapped mode, and
// ceil(2^block_count_log2 / 8) words in fully associative mode (up to 64 at
// 512 blocks), since the single read port delivers eight tags per cycle.
// In the cycle in which busy falls, rsp_valid is high for one cycle with the
// hit flag and the updated counters; the receiver cannot stall, and the next
// access can be transferred in that same cycle. Configuration writes take
// effect at once and belong in idle time.
`default_nettype none
module cache_hit_analyzer #(
   parameter int MAX_BLOCKS = cha_pkg::DEF_MAX_BLOCKS,
   parameter int ADDR_WIDTH = cha_pkg::DEF_ADDR_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [cha_pkg::ADDR_PORT_W-1:0]    req_address,
   input  wire logic                               req_kind,
   output logic                                    rsp_valid,
   output logic                                    rsp_hit,
   output logic      [cha_pkg::CNT_W-1:0]          rsp_instr_accesses,
   output logic      [cha_pkg::CNT_W-1:0]          rsp_instr_hits,
   output logic      [cha_pkg::CNT_W-1:0]          rsp_data_access_count,
   output logic      [cha_pkg::CNT_W-1:0]          rsp_data_hit_count,
   input  wire logic                               csr_write_enable,
   input  wire logic [cha_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cha_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int WORDS   = (MAX_BLOCKS + cha_pkg::LANES - 1) / cha_pkg::LANES;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int MAX_LG  = ((1 << $clog2(MAX_BLOCKS)) == MAX_BLOCKS) ?
                            $clog2(MAX_BLOCKS) : $clog2(MAX_BLOCKS) - 1;

   logic                               mode_ff;
   logic [cha_pkg::CSR_DATA_W-1:0]     offset_ff;
   logic [cha_pkg::CSR_DATA_W-1:0]     log2_ff;
   logic [cha_pkg::CSR_DATA_W-1:0]     offset_eff;
   logic [cha_pkg::CSR_DATA_W-1:0]     log2_eff;

   logic                               rd_en;
   logic [WORD_AW-1:0]                 rd_addr;
   logic [cha_pkg::WORD_W-1:0]         rd_data;
   logic                               wr_en;
   logic [WORD_AW-1:0]                 wr_addr;
   logic [cha_pkg::WORD_W-1:0]         wr_data;
   cha_pkg::result_type                res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cha_pkg::MODE_DIRECT;
         offset_ff <= cha_pkg::OFFSET_RESET;
         log2_ff   <= cha_pkg::LOG2_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cha_pkg::CSR_MODE:        mode_ff   <= csr_write_data[0];
            cha_pkg::CSR_OFFSET_BITS: offset_ff <= csr_write_data;
            cha_pkg::CSR_BLOCK_LOG2:  log2_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (offset_ff < cha_pkg::CSR_DATA_W'(cha_pkg::OFF_MIN)) begin
         offset_eff = cha_pkg::CSR_DATA_W'(cha_pkg::OFF_MIN);
      end else if (offset_ff > cha_pkg::CSR_DATA_W'(cha_pkg::OFF_MAX)) begin
         offset_eff = cha_pkg::CSR_DATA_W'(cha_pkg::OFF_MAX);
      end else begin
         offset_eff = offset_ff;
      end
      if (log2_ff > cha_pkg::CSR_DATA_W'(MAX_LG)) begin
         log2_eff = cha_pkg::CSR_DATA_W'(MAX_LG);
      end else begin
         log2_eff = log2_ff;
      end
   end

   cha_tag_ram #(
      .WORDS (WORDS),
      .AW    (WORD_AW),
      .DW    (cha_pkg::WORD_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   cha_lookup #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .WORDS      (WORDS),
      .WORD_AW    (WORD_AW)
   ) u_lookup (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_address (req_address),
      .req_kind    (req_kind),
      .cfg_mode    (mode_ff),
      .cfg_offset  (offset_eff),
      .cfg_log2    (log2_eff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .res         (res)
   );

   cha_counters u_counters (
      .clock                 (clock),
      .reset                 (reset),
      .res                   (res),
      .rsp_valid             (rsp_valid),
      .rsp_hit               (rsp_hit),
      .rsp_instr_accesses    (rsp_instr_accesses),
      .rsp_instr_hits        (rsp_instr_hits),
      .rsp_data_access_count (rsp_data_access_count),
      .rsp_data_hit_count    (rsp_data_hit_count)
   );

endmodule
`default_nettype wire

>>> test/cache_hit_analyzer_tb.sv
// Self-checking testbench of the cache hit analyzer: directed table, then random phases.
module cache_hit_analyzer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX      = 13;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int REPORT_MAX   = 10;
   localparam int LOG2_LIMIT   = $clog2(cha_pkg::DEF_MAX_BLOCKS + 1) - 1;

   typedef struct packed {
      logic                      hit;
      logic [cha_pkg::CNT_W-1:0] instr_accesses;
      logic [cha_pkg::CNT_W-1:0] instr_hits;
      logic [cha_pkg::CNT_W-1:0] data_access_count;
      logic [cha_pkg::CNT_W-1:0] data_hit_count;
   } lookup_type;

   typedef enum logic {STEP_ACCESS, STEP_WRITE} step_kind_type;

   typedef struct {
      step_kind_type                   op;
      logic [cha_pkg::CSR_IDX_W-1:0]   index;
      logic [cha_pkg::CSR_DATA_W-1:0]  value;
      logic [cha_pkg::ADDR_PORT_W-1:0] address;
      logic                            kind;
      bit                              typed;
      lookup_type                      want;
   } step_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [cha_pkg::ADDR_PORT_W-1:0] req_address;
   logic                            req_kind;
   logic                            rsp_valid;
   logic                            rsp_hit;
   logic [cha_pkg::CNT_W-1:0]       rsp_instr_accesses;
   logic [cha_pkg::CNT_W-1:0]       rsp_instr_hits;
   logic [cha_pkg::CNT_W-1:0]       rsp_data_access_count;
   logic [cha_pkg::CNT_W-1:0]       rsp_data_hit_count;
   logic                            csr_write_enable;
   logic [cha_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [cha_pkg::CSR_DATA_W-1:0]  csr_write_data;

   cache_hit_analyzer u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_address           (req_address),
      .req_kind              (req_kind),
      .rsp_valid             (rsp_valid),
      .rsp_hit               (rsp_hit),
      .rsp_instr_accesses    (rsp_instr_accesses),
      .rsp_instr_hits        (rsp_instr_hits),
      .rsp_data_access_count (rsp_data_access_count),
      .rsp_data_hit_count    (rsp_data_hit_count),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   logic                            cfg_mode;
   logic [cha_pkg::CSR_DATA_W-1:0]  cfg_offset;
   logic [cha_pkg::CSR_DATA_W-1:0]  cfg_log2;
   logic [cha_pkg::TAG_W-1:0]       tag_mem [cha_pkg::DEF_MAX_BLOCKS];
   bit                              line_valid [cha_pkg::DEF_MAX_BLOCKS];
   int unsigned                     fifo_ptr;
   logic [cha_pkg::CNT_W-1:0]       n_instr;
   logic [cha_pkg::CNT_W-1:0]       n_instr_hit;
   logic [cha_pkg::CNT_W-1:0]       n_data;
   logic [cha_pkg::CNT_W-1:0]       n_data_hit;

   lookup_type                      outstanding_lookups[$];
   step_type                        plan[$];
   logic [cha_pkg::ADDR_PORT_W-1:0] hot_addr [8];
   int                              mismatch_count = 0;
   int                              stall_count = 0;
   bit                              start_held;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [cha_pkg::CNT_W-1:0] bump(logic [cha_pkg::CNT_W-1:0] count);
      return (count == '1) ? count : count + 1'b1;
   endfunction

   function automatic lookup_type predict_lookup(logic [cha_pkg::ADDR_PORT_W-1:0] address,
                                                 logic kind);
      int unsigned                     off;
      int unsigned                     lg;
      int unsigned                     blocks;
      int unsigned                     slot;
      int unsigned                     i;
      logic [cha_pkg::ADDR_PORT_W-1:0] line;
      logic [cha_pkg::TAG_W-1:0]       tag;
      bit                              hit;
      off = (cfg_offset < cha_pkg::OFF_MIN) ? cha_pkg::OFF_MIN :
            (cfg_offset > cha_pkg::OFF_MAX) ? cha_pkg::OFF_MAX : cfg_offset;
      lg = (cfg_log2 > LOG2_LIMIT) ? LOG2_LIMIT : cfg_log2;
      blocks = 1 << lg;
      line = address >> off;
      hit = 1'b0;
      if (cfg_mode == cha_pkg::MODE_DIRECT) begin
         slot = line & (blocks - 1);
         tag = cha_pkg::TAG_W'(line >> lg);
         if (line_valid[slot] && tag_mem[slot] == tag) begin
            hit = 1'b1;
         end else begin
            tag_mem[slot] = tag;
            line_valid[slot] = 1'b1;
         end
      end else begin
         for (i = 0; i < blocks; i++) begin
            if (line_valid[i] && tag_mem[i] == cha_pkg::TAG_W'(line)) hit = 1'b1;
         end
         if (!hit) begin
            // A pointer left beyond a shrunken block count restarts at entry zero.
            if (fifo_ptr >= blocks) fifo_ptr = 0;
            tag_mem[fifo_ptr] = cha_pkg::TAG_W'(line);
            line_valid[fifo_ptr] = 1'b1;
            fifo_ptr = (fifo_ptr + 1 >= blocks) ? 0 : fifo_ptr + 1;
         end
      end
      if (kind == cha_pkg::KIND_DATA) begin
         n_data = bump(n_data);
         if (hit) n_data_hit = bump(n_data_hit);
      end else begin
         n_instr = bump(n_instr);
         if (hit) n_instr_hit = bump(n_instr_hit);
      end
      return '{hit, n_instr, n_instr_hit, n_data, n_data_hit};
   endfunction

   function automatic step_type access_row(logic [cha_pkg::ADDR_PORT_W-1:0] address,
                                           logic kind);
      step_type row;
      row = '{STEP_ACCESS, cha_pkg::CSR_MODE, '0, address, kind, 1'b0, '0};
      return row;
   endfunction

   function automatic step_type typed_row(logic [cha_pkg::ADDR_PORT_W-1:0] address,
                                          logic kind, lookup_type want);
      step_type row;
      row = '{STEP_ACCESS, cha_pkg::CSR_MODE, '0, address, kind, 1'b1, want};
      return row;
   endfunction

   function automatic step_type write_row(logic [cha_pkg::CSR_IDX_W-1:0] index,
                                          logic [cha_pkg::CSR_DATA_W-1:0] value);
      step_type row;
      row = '{STEP_WRITE, index, value, '0, cha_pkg::KIND_INSTR, 1'b0, '0};
      return row;
   endfunction

   task automatic wait_idle();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
      while (outstanding_lookups.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [cha_pkg::CSR_IDX_W-1:0] index,
                            logic [cha_pkg::CSR_DATA_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         cha_pkg::CSR_MODE:        cfg_mode = value[0];
         cha_pkg::CSR_OFFSET_BITS: cfg_offset = value;
         cha_pkg::CSR_BLOCK_LOG2:  cfg_log2 = value;
         default: ;
      endcase
   endtask

   task automatic send_access(logic [cha_pkg::ADDR_PORT_W-1:0] address, logic kind, int gap,
                              bit typed, lookup_type want);
      lookup_type predicted;
      req_address <= address;
      req_kind <= kind;
      if (!start_held) begin
         start <= 1'b1;
         start_held = 1'b1;
      end
      do @(posedge clock); while (busy);
      predicted = predict_lookup(address, kind);
      outstanding_lookups.push_back(typed ? want : predicted);
      if (gap > 0) begin
         start <= 1'b0;
         start_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      lookup_type seen;
      lookup_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_hit, rsp_instr_accesses, rsp_instr_hits, rsp_data_access_count,
                  rsp_data_hit_count};
         if (outstanding_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected transfer: hit %0d ia %0d ih %0d da %0d dh %0d",
                        seen.hit, seen.instr_accesses, seen.instr_hits,
                        seen.data_access_count, seen.data_hit_count);
         end else begin
            want = outstanding_lookups.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"mismatch: want hit %0d ia %0d ih %0d da %0d dh %0d, ",
                            "got hit %0d ia %0d ih %0d da %0d dh %0d"},
                           want.hit, want.instr_accesses, want.instr_hits,
                           want.data_access_count, want.data_hit_count,
                           seen.hit, seen.instr_accesses, seen.instr_hits,
                           seen.data_access_count, seen.data_hit_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int                              sent;
      int                              phase_len;
      int                              pick;
      bit                              burst;
      logic [cha_pkg::ADDR_PORT_W-1:0] address;
      reset = 1'b1;
      start = 1'b0;
      start_held = 1'b0;
      req_address = '0;
      req_kind = cha_pkg::KIND_INSTR;
      csr_write_enable = 1'b0;
      csr_index = cha_pkg::CSR_MODE;
      csr_write_data = '0;
      cfg_mode = cha_pkg::MODE_DIRECT;
      cfg_offset = cha_pkg::OFFSET_RESET;
      cfg_log2 = cha_pkg::LOG2_RESET;
      fifo_ptr = 0;
      n_instr = '0;
      n_instr_hit = '0;
      n_data = '0;
      n_data_hit = '0;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      foreach (hot_addr[i]) hot_addr[i] = $urandom();

      plan.push_back(typed_row(32'h0000_0000, cha_pkg::KIND_INSTR,
                               '{1'b0, 32'd1, 32'd0, 32'd0, 32'd0}));
      plan.push_back(typed_row(32'h0000_003F, cha_pkg::KIND_DATA,
                               '{1'b1, 32'd1, 32'd0, 32'd1, 32'd1}));
      plan.push_back(typed_row(32'hFFFF_FFFF, cha_pkg::KIND_INSTR,
                               '{1'b0, 32'd2, 32'd0, 32'd1, 32'd1}));
      plan.push_back(typed_row(32'hFFFF_FFC0, cha_pkg::KIND_DATA,
                               '{1'b1, 32'd2, 32'd0, 32'd2, 32'd2}));
      plan.push_back(access_row(32'h0000_0800, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h0000_0000, cha_pkg::KIND_DATA));
      plan.push_back(write_row(cha_pkg::CSR_OFFSET_BITS, 4'd0));
      plan.push_back(write_row(cha_pkg::CSR_BLOCK_LOG2, 4'd15));
      plan.push_back(access_row(32'h1234_5678, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h1234_5670, cha_pkg::KIND_DATA));
      plan.push_back(access_row(32'h1234_7678, cha_pkg::KIND_INSTR));
      plan.push_back(write_row(cha_pkg::CSR_MODE, cha_pkg::CSR_DATA_W'(cha_pkg::MODE_ASSOC)));
      plan.push_back(write_row(cha_pkg::CSR_OFFSET_BITS, 4'd15));
      plan.push_back(write_row(cha_pkg::CSR_BLOCK_LOG2, 4'd0));
      plan.push_back(access_row(32'h0000_0100, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h0000_01FF, cha_pkg::KIND_DATA));
      plan.push_back(access_row(32'h0000_0200, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h0000_0100, cha_pkg::KIND_DATA));
      plan.push_back(write_row(cha_pkg::CSR_BLOCK_LOG2, 4'd3));
      plan.push_back(access_row(32'h0000_0300, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h0000_0400, cha_pkg::KIND_DATA));
      plan.push_back(access_row(32'h0000_0500, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'h0000_0600, cha_pkg::KIND_DATA));
      plan.push_back(write_row(cha_pkg::CSR_BLOCK_LOG2, 4'd1));
      plan.push_back(access_row(32'h0000_0700, cha_pkg::KIND_DATA));
      plan.push_back(access_row(32'h0000_0600, cha_pkg::KIND_INSTR));
      plan.push_back(write_row(cha_pkg::CSR_MODE, cha_pkg::CSR_DATA_W'(cha_pkg::MODE_DIRECT)));
      plan.push_back(write_row(cha_pkg::CSR_OFFSET_BITS, 4'd8));
      plan.push_back(access_row(32'h0000_0700, cha_pkg::KIND_INSTR));
      plan.push_back(write_row(cha_pkg::CSR_MODE, cha_pkg::CSR_DATA_W'(cha_pkg::MODE_ASSOC)));
      plan.push_back(write_row(cha_pkg::CSR_OFFSET_BITS, 4'd4));
      plan.push_back(write_row(cha_pkg::CSR_BLOCK_LOG2, 4'd9));
      plan.push_back(access_row(32'hFFFF_FFF0, cha_pkg::KIND_DATA));
      plan.push_back(access_row(32'h0000_000F, cha_pkg::KIND_INSTR));
      plan.push_back(access_row(32'hFFFF_FFFF, cha_pkg::KIND_INSTR));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // The block clears its tag memory after reset and holds busy until done.
      do @(posedge clock); while (!busy);
      while (busy) @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].op == STEP_WRITE)
            write_csr(plan[i].index, plan[i].value);
         else
            send_access(plan[i].address, plan[i].kind, $urandom_range(0, GAP_MAX),
                        plan[i].typed, plan[i].want);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_csr(cha_pkg::CSR_MODE, cha_pkg::CSR_DATA_W'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0)
            write_csr(cha_pkg::CSR_OFFSET_BITS, cha_pkg::CSR_DATA_W'($urandom_range(0, 15)));
         else
            write_csr(cha_pkg::CSR_OFFSET_BITS,
                      cha_pkg::CSR_DATA_W'($urandom_range(cha_pkg::OFF_MIN, cha_pkg::OFF_MAX)));
         pick = $urandom_range(0, 9);
         if (pick < 6)
            write_csr(cha_pkg::CSR_BLOCK_LOG2, cha_pkg::CSR_DATA_W'($urandom_range(0, 4)));
         else if (pick < 9)
            write_csr(cha_pkg::CSR_BLOCK_LOG2, cha_pkg::CSR_DATA_W'($urandom_range(5, 8)));
         else
            write_csr(cha_pkg::CSR_BLOCK_LOG2, cha_pkg::CSR_DATA_W'($urandom_range(9, 15)));
         foreach (hot_addr[i]) if ($urandom_range(0, 1) == 0) hot_addr[i] = $urandom();
         burst = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
               address = hot_addr[$urandom_range(0, 7)]
                         ^ cha_pkg::ADDR_PORT_W'($urandom_range(0, 255));
            else if (pick < 8)
               address = hot_addr[$urandom_range(0, 7)]
                         + cha_pkg::ADDR_PORT_W'($urandom_range(0, 15) << 8);
            else
               address = $urandom();
            send_access(address, 1'($urandom_range(0, 1)),
                        burst ? 0 : $urandom_range(0, GAP_MAX), 1'b0, '0);
         end
         sent += phase_len;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += outstanding_lookups.size();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
rtl/cha_pkg.sv
rtl/cha_tag_ram.sv
rtl/cha_lookup.sv
rtl/cha_counters.sv
rtl/cache_hit_analyzer.sv
test/cache_hit_analyzer_tb.sv
